>>> design/msd_pkg.sv
// msd_pkg: shared types, constants and helper functions for the
// multiplexed seven-segment display controller
// no dependencies
package msd_pkg;

    localparam int DIGITS = 4;
    localparam int IDX_W  = (DIGITS > 1) ? $clog2(DIGITS) : 1;

    localparam logic [7:0] POINT_BIT  = 8'h80;
    localparam logic [7:0] PERIOD_RST = 8'd5;

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_DEC   = 2'd1,
        CMD_RAW   = 2'd2,
        CMD_TIME  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_RANGE = 2'd1,
        STATUS_INDEX = 2'd2
    } status_t;

    typedef struct packed {
        cmd_t       cmd;
        logic [3:0] digit_index;
        logic [7:0] digit_value;
        logic       with_point;
        logic [4:0] hours;
        logic [5:0] minutes;
    } item_t;

    typedef struct packed {
        status_t    status;
        logic [7:0] segments;
        logic [2:0] active_digit;
        logic       digit_on;
    } res_t;

    function automatic logic [7:0] seg_code(input logic [3:0] d);
        logic [7:0] s;
        case (d)
            4'd0:    s = 8'h7E;
            4'd1:    s = 8'h30;
            4'd2:    s = 8'h6D;
            4'd3:    s = 8'h79;
            4'd4:    s = 8'h33;
            4'd5:    s = 8'h5B;
            4'd6:    s = 8'h5F;
            4'd7:    s = 8'h70;
            4'd8:    s = 8'h7F;
            4'd9:    s = 8'h7B;
            default: s = 8'h00;
        endcase
        return s;
    endfunction

    // tens digit of a value below 64
    function automatic logic [2:0] tens_of(input logic [5:0] v);
        logic [2:0] t;
        if (v >= 6'd60)
            t = 3'd6;
        else if (v >= 6'd50)
            t = 3'd5;
        else if (v >= 6'd40)
            t = 3'd4;
        else if (v >= 6'd30)
            t = 3'd3;
        else if (v >= 6'd20)
            t = 3'd2;
        else if (v >= 6'd10)
            t = 3'd1;
        else
            t = 3'd0;
        return t;
    endfunction

    function automatic logic [3:0] ones_of(input logic [5:0] v);
        logic [5:0] r;
        r = v - ({3'b000, tens_of(v)} * 6'd10);
        return r[3:0];
    endfunction

endpackage

>>> design/msd_in_reg.sv
// msd_in_reg: input register holding one accepted command word
// depends on msd_pkg
module msd_in_reg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [1:0]        cmd,
    input  logic [3:0]        digit_index,
    input  logic [7:0]        digit_value,
    input  logic              with_point,
    input  logic [4:0]        hours,
    input  logic [5:0]        minutes,
    input  logic              take,
    output logic              full,
    output msd_pkg::item_t    item
);

    logic           full_reg;
    logic           full_next;
    msd_pkg::item_t item_reg;
    logic           load;

    assign in_stall = full_reg && !take;
    assign load     = in_valid && !in_stall;

    always_comb
    begin
        if (load)
            full_next = 1'b1;
        else if (take)
            full_next = 1'b0;
        else
            full_next = full_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            full_reg <= 1'b0;
        else
            full_reg <= full_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg.cmd         <= msd_pkg::cmd_t'(cmd);
            item_reg.digit_index <= digit_index;
            item_reg.digit_value <= digit_value;
            item_reg.with_point  <= with_point;
            item_reg.hours       <= hours;
            item_reg.minutes     <= minutes;
        end
    end

    assign full = full_reg;
    assign item = item_reg;

endmodule

>>> design/msd_core.sv
// msd_core: digit pattern store, scan timer and scan position, with the
// result of the word being executed
// depends on msd_pkg
module msd_core (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  msd_pkg::item_t item,
    input  logic [7:0]     scan_period,
    output msd_pkg::res_t  result
);

    logic [7:0]              pattern_reg [msd_pkg::DIGITS];
    logic [7:0]              pattern_next [msd_pkg::DIGITS];
    logic [msd_pkg::IDX_W-1:0] scan_pos_reg;
    logic [msd_pkg::IDX_W-1:0] scan_pos_next;
    logic [7:0]              tick_reg;
    logic [7:0]              tick_next;
    logic [7:0]              drv_pat_reg;
    logic [7:0]              drv_pat_next;
    logic [msd_pkg::IDX_W-1:0] drv_dig_reg;
    logic [msd_pkg::IDX_W-1:0] drv_dig_next;
    logic                    any_reg;
    logic                    any_next;
    msd_pkg::status_t        status;

    logic [8:0]              count;
    logic [7:0]              period;
    logic [msd_pkg::IDX_W:0] pos_inc;
    logic                    idx_bad;
    logic [msd_pkg::IDX_W-1:0] widx;

    assign period  = (scan_period == 8'd0) ? 8'd1 : scan_period;
    assign count   = {1'b0, tick_reg} + 9'd1;
    assign pos_inc = {1'b0, scan_pos_reg} + {{msd_pkg::IDX_W{1'b0}}, 1'b1};
    assign idx_bad = item.digit_index >= 4'(msd_pkg::DIGITS);
    assign widx    = item.digit_index[msd_pkg::IDX_W-1:0];

    always_comb
    begin
        pattern_next  = pattern_reg;
        scan_pos_next = scan_pos_reg;
        tick_next     = tick_reg;
        drv_pat_next  = drv_pat_reg;
        drv_dig_next  = drv_dig_reg;
        any_next      = any_reg;
        status        = msd_pkg::STATUS_OK;
        case (item.cmd)
            msd_pkg::CMD_TICK:
            begin
                if (count >= {1'b0, period})
                begin
                    tick_next    = 8'd0;
                    drv_pat_next = pattern_reg[scan_pos_reg];
                    drv_dig_next = scan_pos_reg;
                    any_next     = 1'b1;
                    if (pos_inc >= (msd_pkg::IDX_W+1)'(msd_pkg::DIGITS))
                        scan_pos_next = '0;
                    else
                        scan_pos_next = pos_inc[msd_pkg::IDX_W-1:0];
                end
                else
                begin
                    tick_next = count[7:0];
                end
            end
            msd_pkg::CMD_DEC:
            begin
                if (idx_bad)
                    status = msd_pkg::STATUS_INDEX;
                else if (item.digit_value > 8'd9)
                    status = msd_pkg::STATUS_RANGE;
                else
                    pattern_next[widx] = msd_pkg::seg_code(item.digit_value[3:0])
                                       | (item.with_point ? msd_pkg::POINT_BIT : 8'h00);
            end
            msd_pkg::CMD_RAW:
            begin
                if (idx_bad)
                    status = msd_pkg::STATUS_INDEX;
                else
                    pattern_next[widx] = item.digit_value;
            end
            msd_pkg::CMD_TIME:
            begin
                pattern_next[0] = msd_pkg::seg_code({1'b0,
                                      msd_pkg::tens_of({1'b0, item.hours})});
                pattern_next[1] = msd_pkg::seg_code(msd_pkg::ones_of({1'b0, item.hours}))
                                | msd_pkg::POINT_BIT;
                pattern_next[2] = msd_pkg::seg_code({1'b0,
                                      msd_pkg::tens_of(item.minutes)});
                pattern_next[3] = msd_pkg::seg_code(msd_pkg::ones_of(item.minutes));
            end
            default:
            begin
                status = msd_pkg::STATUS_OK;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < msd_pkg::DIGITS; i++)
                pattern_reg[i] <= 8'd0;
            scan_pos_reg <= '0;
            tick_reg     <= 8'd0;
            drv_pat_reg  <= 8'd0;
            drv_dig_reg  <= '0;
            any_reg      <= 1'b0;
        end
        else if (en)
        begin
            pattern_reg  <= pattern_next;
            scan_pos_reg <= scan_pos_next;
            tick_reg     <= tick_next;
            drv_pat_reg  <= drv_pat_next;
            drv_dig_reg  <= drv_dig_next;
            any_reg      <= any_next;
        end
    end

    assign result.status       = status;
    assign result.segments     = drv_pat_next;
    assign result.active_digit = 3'(drv_dig_next);
    assign result.digit_on     = any_next;

endmodule

>>> design/multiplexed_seven_segment_display.sv
// multiplexed_seven_segment_display: top level with scan period register,
// input register, core and result register
// depends on msd_pkg, msd_in_reg, msd_core
//
//  channel  | handshake            | payload
//  ---------+----------------------+---------------------------------------------
//  in       | in_valid / in_stall  | cmd digit_index digit_value with_point hours minutes
//  out      | out_valid / out_stall| status segments active_digit digit_on
//  cfg      | cfg_valid / cfg_ready| cfg_data (scan period)
//
// an accepted word passes the input register, then the core update into the
// result register; one word per cycle sustained while out_stall is low
// out_stall holds a valid result register and, once the input register is
// full, stalls the input side through the same cycle
// rst_n clears all control state, the digit patterns and sets the scan
// period to 5; cfg_ready is always high
module multiplexed_seven_segment_display (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] cmd,
    input  logic [3:0] digit_index,
    input  logic [7:0] digit_value,
    input  logic       with_point,
    input  logic [4:0] hours,
    input  logic [5:0] minutes,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [1:0] status,
    output logic [7:0] segments,
    output logic [2:0] active_digit,
    output logic       digit_on,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_data
);

    logic           cfg_write;
    logic [7:0]     scan_period_reg;
    logic           out_valid_reg;
    logic           out_valid_next;
    msd_pkg::res_t  res_reg;
    msd_pkg::res_t  core_res;
    msd_pkg::item_t item;
    logic           full;
    logic           take;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            scan_period_reg <= msd_pkg::PERIOD_RST;
        else if (cfg_write)
            scan_period_reg <= cfg_data;
    end

    assign take = full && (!out_valid_reg || !out_stall);

    msd_in_reg u_in_reg (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .cmd         (cmd),
        .digit_index (digit_index),
        .digit_value (digit_value),
        .with_point  (with_point),
        .hours       (hours),
        .minutes     (minutes),
        .take        (take),
        .full        (full),
        .item        (item)
    );

    msd_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (take),
        .item        (item),
        .scan_period (scan_period_reg),
        .result      (core_res)
    );

    always_comb
    begin
        if (take)
            out_valid_next = 1'b1;
        else if (out_stall)
            out_valid_next = out_valid_reg;
        else
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (take)
            res_reg <= core_res;
    end

    assign out_valid    = out_valid_reg;
    assign status       = res_reg.status;
    assign segments     = res_reg.segments;
    assign active_digit = res_reg.active_digit;
    assign digit_on     = res_reg.digit_on;

`ifndef SYNTH
    // a held word is not dropped while the result side is blocked
    a_hold_word: assert property (@(posedge clk) disable iff (!rst_n)
        full && !take |=> full)
        else $error("input word lost while stalled");

    // nothing lit before the first digit is switched on
    a_dark_before_on: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !digit_on |-> segments == 8'd0 && active_digit == 3'd0)
        else $error("segments lit before any digit switched on");

    // scan never points past the last digit
    a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> active_digit < 3'(msd_pkg::DIGITS))
        else $error("active digit out of range");

    // input stalls only when a word is waiting
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> full && out_valid && out_stall)
        else $error("input stalled without cause");
`endif

endmodule
